>>> rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the Feistel block cipher unit
// Widths, register indexes, reset values, opcodes and the sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none
package fbc_pkg;

  localparam int unsigned BLK_W   = 64;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned RND_W   = 8;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDAT_W  = 64;
  localparam int unsigned TUSER_W = 2;

  // Round function rotate amounts and the odd-round key rotation
  localparam int unsigned ROT_X   = 9;
  localparam int unsigned ROT_K   = 11;
  localparam int unsigned ROT_ODD = 8;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE_KEY    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROUND_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_CHAIN_MODE  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_INIT_VECTOR = 2'd3;

  // Register reset values
  localparam logic [WORD_W-1:0] RST_BASE_KEY    = 16'd0;
  localparam logic [RND_W-1:0]  RST_ROUND_COUNT = 8'd249;
  localparam logic              RST_CHAIN_MODE  = 1'b1;
  localparam logic [BLK_W-1:0]  RST_INIT_VECTOR = 64'd1;

  // Opcodes and chaining modes
  localparam logic OP_ENC    = 1'b0;
  localparam logic OP_DEC    = 1'b1;
  localparam logic MODE_ECB  = 1'b0;
  localparam logic MODE_CBC  = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;     // take the input beat into the datapath
    logic step;     // apply one Feistel round
    logic finish;   // write the result and the chaining value
    logic odd_key;  // current round index is odd
  } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/fbc_round.sv
// ----------------------------------------------------------------------------
// fbc_round: one Feistel round, shared across all rounds of a block
// Forms the round subkey, evaluates the round function once and shuffles
// the four 16-bit words for an encryption or a decryption round.
// ----------------------------------------------------------------------------
`default_nettype none
module fbc_round (
  input  wire logic [fbc_pkg::BLK_W-1:0]  blk,
  input  wire logic [fbc_pkg::WORD_W-1:0] base_key,
  input  wire logic                       odd_key,
  input  wire logic                       dec,
  output logic      [fbc_pkg::BLK_W-1:0]  blk_nxt
);

  logic [fbc_pkg::WORD_W-1:0] w0, w1, w2, w3;
  logic [fbc_pkg::WORD_W-1:0] subkey;
  logic [fbc_pkg::WORD_W-1:0] key_rot;
  logic [fbc_pkg::WORD_W-1:0] x;
  logic [fbc_pkg::WORD_W-1:0] x_rot;
  logic [fbc_pkg::WORD_W-1:0] f_out;

  assign w0 = blk[15:0];
  assign w1 = blk[31:16];
  assign w2 = blk[47:32];
  assign w3 = blk[63:48];

  // Odd rounds use the key rotated right by a byte
  assign subkey = odd_key ? {base_key[fbc_pkg::ROT_ODD-1:0],
                             base_key[fbc_pkg::WORD_W-1:fbc_pkg::ROT_ODD]}
                          : base_key;

  // Encryption feeds the low word, decryption the high word
  assign x = dec ? w3 : w0;

  // rotr(k,11) and rotl(x,9)
  assign key_rot = {subkey[fbc_pkg::ROT_K-1:0],
                    subkey[fbc_pkg::WORD_W-1:fbc_pkg::ROT_K]};
  assign x_rot   = {x[fbc_pkg::WORD_W-fbc_pkg::ROT_X-1:0],
                    x[fbc_pkg::WORD_W-1:fbc_pkg::WORD_W-fbc_pkg::ROT_X]};
  assign f_out   = x_rot ^ ~(key_rot ^ x);

  // Shuffle words
  always_comb begin
    if (dec) begin
      blk_nxt = {w2, w1, f_out ^ w0, x};
    end else begin
      blk_nxt = {w0, w3, w2, f_out ^ w1};
    end
  end

endmodule
`default_nettype wire

>>> rtl/fbc_ctrl.sv
// ----------------------------------------------------------------------------
// fbc_ctrl: round sequencer
// Counts the remaining rounds, tracks the round index parity and hands
// load, step and finish commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module fbc_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      dec,
  input  wire logic                      out_free,
  input  wire logic [fbc_pkg::RND_W-1:0] round_count,
  output logic                           in_ready,
  output fbc_pkg::ctrl_t                 ctrl
);

  fbc_pkg::st_t              state_r, state_nxt;
  logic [fbc_pkg::RND_W-1:0] rem_r, rem_nxt;
  logic                      par_r, par_nxt;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbc_pkg::ST_IDLE;
      rem_r   <= '0;
      par_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      par_r   <= par_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    par_nxt      = par_r;
    in_ready     = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.step    = 1'b0;
    ctrl.finish  = 1'b0;
    ctrl.odd_key = par_r;
    case (state_r)
      fbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          rem_nxt   = round_count;
          // Decryption starts at the last round index
          par_nxt   = dec ? ~round_count[0] : 1'b0;
          state_nxt = fbc_pkg::ST_RUN;
        end
      end
      fbc_pkg::ST_RUN: begin
        if (rem_r != '0) begin
          ctrl.step = 1'b1;
          rem_nxt   = rem_r - 1'b1;
          par_nxt   = ~par_r;
        end else if (out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = fbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/feistel_block_cipher_cbc_unit.sv
// ----------------------------------------------------------------------------
// feistel_block_cipher_cbc_unit: Feistel block cipher with CBC chaining
// Encrypts or decrypts 64-bit blocks with a four-word Feistel network,
// optionally chained in CBC mode.
// ----------------------------------------------------------------------------
// Each block is loaded, then stepped round by round through the single shared
// round unit, and finally the result register (and, in CBC mode, the chaining
// value) is written; only then can the next input beat be taken. The input
// side is not ready while a block is in flight. A result waits in the output
// register without blocking the next input beat; only the finish of the
// following block waits for that result to be taken. Setting tuser bit 1
// (restart) reloads the chaining value from init_vector before the block is
// used.
// ----------------------------------------------------------------------------
`default_nettype none
module feistel_block_cipher_cbc_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [fbc_pkg::BLK_W-1:0]     in_tdata,  // [63:0] data_block
  input  wire logic [fbc_pkg::TUSER_W-1:0]   in_tuser,  // [0] opcode, [1] restart
  // Result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [fbc_pkg::BLK_W-1:0]     out_tdata, // [63:0] result_block
  // Configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [fbc_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [fbc_pkg::CDAT_W-1:0]    cfg_wdata
);

  logic [fbc_pkg::WORD_W-1:0] base_key_r;
  logic [fbc_pkg::RND_W-1:0]  round_count_r;
  logic                       chain_mode_r;
  logic [fbc_pkg::BLK_W-1:0]  init_vector_r;

  logic [fbc_pkg::BLK_W-1:0]  chain_r;
  logic [fbc_pkg::BLK_W-1:0]  blk_r;
  logic [fbc_pkg::BLK_W-1:0]  din_r;
  logic                       dec_r;
  logic                       cbc_r;
  logic                       out_valid_r;
  logic [fbc_pkg::BLK_W-1:0]  out_data_r;

  logic                       in_dec;
  logic                       in_restart;
  logic [fbc_pkg::BLK_W-1:0]  cv;
  logic [fbc_pkg::BLK_W-1:0]  round_out;
  logic [fbc_pkg::BLK_W-1:0]  result;
  logic                       out_free;
  fbc_pkg::ctrl_t             ctrl;

  assign in_dec     = (in_tuser[0] == fbc_pkg::OP_DEC);
  assign in_restart = in_tuser[1];
  assign cv         = in_restart ? init_vector_r : chain_r;
  assign out_free   = !out_valid_r || out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_key_r    <= fbc_pkg::RST_BASE_KEY;
      round_count_r <= fbc_pkg::RST_ROUND_COUNT;
      chain_mode_r  <= fbc_pkg::RST_CHAIN_MODE;
      init_vector_r <= fbc_pkg::RST_INIT_VECTOR;
    end else if (cfg_we) begin
      case (cfg_index)
        fbc_pkg::CFG_BASE_KEY:    base_key_r    <= cfg_wdata[fbc_pkg::WORD_W-1:0];
        fbc_pkg::CFG_ROUND_COUNT: round_count_r <= cfg_wdata[fbc_pkg::RND_W-1:0];
        fbc_pkg::CFG_CHAIN_MODE:  chain_mode_r  <= cfg_wdata[0];
        fbc_pkg::CFG_INIT_VECTOR: init_vector_r <= cfg_wdata[fbc_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // Round sequencer
  fbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .dec         (in_dec),
    .out_free    (out_free),
    .round_count (round_count_r),
    .in_ready    (in_tready),
    .ctrl        (ctrl)
  );

  // Shared round unit
  fbc_round u_round (
    .blk      (blk_r),
    .base_key (base_key_r),
    .odd_key  (ctrl.odd_key),
    .dec      (dec_r),
    .blk_nxt  (round_out)
  );

  // Block register: load with CBC pre-whitening for encryption, then advance one round a cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      blk_r <= (chain_mode_r == fbc_pkg::MODE_CBC && !in_dec) ? (in_tdata ^ cv)
                                                               : in_tdata;
      din_r <= in_tdata;
      dec_r <= in_dec;
      cbc_r <= (chain_mode_r == fbc_pkg::MODE_CBC);
    end else if (ctrl.step) begin
      blk_r <= round_out;
    end
  end

  // Decryption in CBC mode unwhitens with the chaining value
  assign result = (cbc_r && dec_r) ? (blk_r ^ chain_r) : blk_r;

  // Chaining value: reload on restart, then take the ciphertext in CBC mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (ctrl.load) begin
      chain_r <= cv;
    end else if (ctrl.finish && cbc_r) begin
      chain_r <= dec_r ? din_r : blk_r;
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/fbc_checker.sv
// ----------------------------------------------------------------------------
// fbc_checker: port-level checks for the Feistel block cipher unit
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
module fbc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [fbc_pkg::BLK_W-1:0]   out_tdata
);

  // A stalled result beat holds its data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // Reset leaves the unit ready with no result pending
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("unit not idle after reset");

  // The input side is not ready in the cycle after a block is accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a block is in flight");

  // No result can appear in the cycle right after a block is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared without running the rounds");

endmodule

bind feistel_block_cipher_cbc_unit fbc_checker u_fbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> test/feistel_block_cipher_cbc_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feistel_block_cipher_cbc_unit_tb: self-checking bench for the Feistel unit
// Walks a short directed table (reset values, zero and full round counts,
// ECB and CBC chaining, restarts), then random blocks over several register
// settings and idling patterns. Each result beat is compared against a typed
// row value or an in-bench cipher predictor tracking registers and chaining.
// ----------------------------------------------------------------------------
module feistel_block_cipher_cbc_unit_tb;

  localparam int QUIET_LIMIT   = 4000;  // cycles without any beat
  localparam int HOLD_CYCLES   = 600;   // long output back-pressure stretch
  localparam int SETTLE_CYCLES = 300;   // longer than one 255-round block
  localparam int NUM_PHASES    = 12;
  localparam int PRESSURE_PH   = 4;

  typedef enum logic {ROW_BLOCK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [fbc_pkg::CIDX_W-1:0] idx;
    logic [fbc_pkg::BLK_W-1:0]  val;    // block data or register value
    logic                       op;
    logic                       rs;
    logic                       known;  // expected result typed in the row
    logic [fbc_pkg::BLK_W-1:0]  want;
  } row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [fbc_pkg::BLK_W-1:0]    in_tdata;   // [63:0] data_block
  logic [fbc_pkg::TUSER_W-1:0]  in_tuser;   // [0] opcode, [1] restart
  logic                         out_tvalid;
  logic                         out_tready;
  logic [fbc_pkg::BLK_W-1:0]    out_tdata;  // [63:0] result_block
  logic                         cfg_we;
  logic [fbc_pkg::CIDX_W-1:0]   cfg_index;
  logic [fbc_pkg::CDAT_W-1:0]   cfg_wdata;

  // Shadow registers and chaining state of the predictor
  logic [fbc_pkg::WORD_W-1:0]   key_reg;
  logic [fbc_pkg::RND_W-1:0]    rounds_reg;
  logic                         mode_reg;
  logic [fbc_pkg::BLK_W-1:0]    iv_reg;
  logic [fbc_pkg::BLK_W-1:0]    chain_val;

  logic [fbc_pkg::BLK_W-1:0]    expected_blocks [$];
  row_t                         dir_rows [$];
  int                           mismatches;
  int                           quiet_cycles;
  int                           send_idle_pct;
  int                           stall_pct;
  bit                           hold_req;
  logic [fbc_pkg::BLK_W-1:0]    want_blk;

  feistel_block_cipher_cbc_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Cipher predictor
  // --------------------------------------------------------------------------
  function automatic logic [fbc_pkg::WORD_W-1:0] rol_word(
      input logic [fbc_pkg::WORD_W-1:0] v, input int unsigned s);
    return (v << s) | (v >> (fbc_pkg::WORD_W - s));
  endfunction

  function automatic logic [fbc_pkg::WORD_W-1:0] ror_word(
      input logic [fbc_pkg::WORD_W-1:0] v, input int unsigned s);
    return (v >> s) | (v << (fbc_pkg::WORD_W - s));
  endfunction

  // Even rounds use the key as is, odd rounds the key turned by a byte
  function automatic logic [fbc_pkg::WORD_W-1:0] round_key(input int r);
    return (r % 2 != 0) ? ror_word(key_reg, fbc_pkg::ROT_ODD) : key_reg;
  endfunction

  function automatic logic [fbc_pkg::WORD_W-1:0] round_mix(
      input logic [fbc_pkg::WORD_W-1:0] x, input logic [fbc_pkg::WORD_W-1:0] k);
    return rol_word(x, fbc_pkg::ROT_X) ^ ~(ror_word(k, fbc_pkg::ROT_K) ^ x);
  endfunction

  function automatic logic [fbc_pkg::BLK_W-1:0] encipher(
      input logic [fbc_pkg::BLK_W-1:0] blk);
    logic [fbc_pkg::WORD_W-1:0] w0, w1, w2, w3, nxt;
    {w3, w2, w1, w0} = blk;
    for (int r = 0; r < int'(rounds_reg); r++) begin
      nxt = round_mix(w0, round_key(r)) ^ w1;
      w1  = w2;
      w2  = w3;
      w3  = w0;
      w0  = nxt;
    end
    return {w3, w2, w1, w0};
  endfunction

  // Undo the rounds from the last one down to the first
  function automatic logic [fbc_pkg::BLK_W-1:0] decipher(
      input logic [fbc_pkg::BLK_W-1:0] blk);
    logic [fbc_pkg::WORD_W-1:0] w0, w1, w2, w3, x, nxt;
    {w3, w2, w1, w0} = blk;
    for (int r = int'(rounds_reg); r > 0; r--) begin
      x   = w3;
      nxt = round_mix(x, round_key(r - 1)) ^ w0;
      w3  = w2;
      w2  = w1;
      w1  = nxt;
      w0  = x;
    end
    return {w3, w2, w1, w0};
  endfunction

  // Result of one accepted block; advances the chaining value in CBC mode
  function automatic logic [fbc_pkg::BLK_W-1:0] predict_block(
      input logic op, input logic [fbc_pkg::BLK_W-1:0] blk, input logic rs);
    logic [fbc_pkg::BLK_W-1:0] res;
    if (rs) chain_val = iv_reg;
    if (mode_reg == fbc_pkg::MODE_CBC) begin
      if (op == fbc_pkg::OP_ENC) begin
        res       = encipher(blk ^ chain_val);
        chain_val = res;
      end else begin
        res       = decipher(blk) ^ chain_val;
        chain_val = blk;
      end
    end else begin
      res = (op == fbc_pkg::OP_ENC) ? encipher(blk) : decipher(blk);
    end
    return res;
  endfunction

  function automatic void apply_cfg(input logic [fbc_pkg::CIDX_W-1:0] idx,
                                    input logic [fbc_pkg::CDAT_W-1:0] val);
    case (idx)
      fbc_pkg::CFG_BASE_KEY:    key_reg    = val[fbc_pkg::WORD_W-1:0];
      fbc_pkg::CFG_ROUND_COUNT: rounds_reg = val[fbc_pkg::RND_W-1:0];
      fbc_pkg::CFG_CHAIN_MODE:  mode_reg   = val[0];
      fbc_pkg::CFG_INIT_VECTOR: iv_reg     = val;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table rows
  // --------------------------------------------------------------------------
  function automatic row_t blk_row(input logic op,
                                   input logic [fbc_pkg::BLK_W-1:0] blk,
                                   input logic rs);
    return '{ROW_BLOCK, fbc_pkg::CFG_BASE_KEY, blk, op, rs, 1'b0, '0};
  endfunction

  function automatic row_t known_row(input logic op,
                                     input logic [fbc_pkg::BLK_W-1:0] blk,
                                     input logic rs,
                                     input logic [fbc_pkg::BLK_W-1:0] want);
    return '{ROW_BLOCK, fbc_pkg::CFG_BASE_KEY, blk, op, rs, 1'b1, want};
  endfunction

  function automatic row_t cfg_row(input logic [fbc_pkg::CIDX_W-1:0] idx,
                                   input logic [fbc_pkg::CDAT_W-1:0] val);
    return '{ROW_CFG, idx, val, fbc_pkg::OP_ENC, 1'b0, 1'b0, '0};
  endfunction

  // Append a row to the directed table
  function automatic void add_row(input row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what,
                               input logic [fbc_pkg::BLK_W-1:0] got,
                               input logic [fbc_pkg::BLK_W-1:0] want);
    mismatches++;
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Offer one block, hold it until taken, then queue its expected result
  task automatic send_block(input logic op, input logic [fbc_pkg::BLK_W-1:0] blk,
                            input logic rs, input logic known,
                            input logic [fbc_pkg::BLK_W-1:0] want);
    logic [fbc_pkg::BLK_W-1:0] model_out;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tuser  <= {rs, op};
    do @(posedge clk); while (!in_tready);
    model_out       = predict_block(op, blk, rs);
    expected_blocks = {expected_blocks, (known ? want : model_out)};
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_blocks();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fbc_pkg::CIDX_W-1:0] idx,
                           input logic [fbc_pkg::CDAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_cfg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        note_mismatch("result beat with nothing pending", out_tdata, '0);
      end else begin
        want_blk = expected_blocks.pop_front();
        if (out_tdata !== want_blk)
          note_mismatch("result_block", out_tdata, want_blk);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [fbc_pkg::RND_W-1:0]  rounds;
    logic [fbc_pkg::WORD_W-1:0] key;
    logic [fbc_pkg::BLK_W-1:0]  iv;
    logic                       mode;
    int                         n_items;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_we        = 1'b0;
    cfg_index     = fbc_pkg::CFG_BASE_KEY;
    cfg_wdata     = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    key_reg       = fbc_pkg::RST_BASE_KEY;
    rounds_reg    = fbc_pkg::RST_ROUND_COUNT;
    mode_reg      = fbc_pkg::RST_CHAIN_MODE;
    iv_reg        = fbc_pkg::RST_INIT_VECTOR;
    chain_val     = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: chaining from zero, then a restart from the reset IV
    add_row(blk_row(fbc_pkg::OP_ENC, 64'h0, 1'b0));
    add_row(blk_row(fbc_pkg::OP_DEC, '1, 1'b0));
    add_row(blk_row(fbc_pkg::OP_ENC, 64'h0123_4567_89AB_CDEF, 1'b1));
    // Zero rounds in ECB: identity, restart has no effect
    add_row(cfg_row(fbc_pkg::CFG_ROUND_COUNT, 64'd0));
    add_row(cfg_row(fbc_pkg::CFG_CHAIN_MODE,
                    fbc_pkg::CDAT_W'(fbc_pkg::MODE_ECB)));
    add_row(known_row(fbc_pkg::OP_ENC, '1, 1'b0, '1));
    add_row(known_row(fbc_pkg::OP_DEC, 64'h0, 1'b0, 64'h0));
    add_row(known_row(fbc_pkg::OP_ENC, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
                      64'hA5A5_A5A5_A5A5_A5A5));
    // Zero rounds in CBC: only the chaining xor remains
    add_row(cfg_row(fbc_pkg::CFG_CHAIN_MODE,
                    fbc_pkg::CDAT_W'(fbc_pkg::MODE_CBC)));
    add_row(cfg_row(fbc_pkg::CFG_INIT_VECTOR, '1));
    add_row(known_row(fbc_pkg::OP_ENC, 64'h0, 1'b1, '1));
    add_row(known_row(fbc_pkg::OP_ENC, '1, 1'b0, 64'h0));
    add_row(known_row(fbc_pkg::OP_DEC, 64'h1234_5678_9ABC_DEF0, 1'b0,
                      64'h1234_5678_9ABC_DEF0));
    add_row(known_row(fbc_pkg::OP_DEC, 64'h0, 1'b0, 64'h1234_5678_9ABC_DEF0));
    // Full round count with an all-ones key
    add_row(cfg_row(fbc_pkg::CFG_ROUND_COUNT, 64'd255));
    add_row(cfg_row(fbc_pkg::CFG_BASE_KEY, 64'hFFFF));
    add_row(blk_row(fbc_pkg::OP_ENC, 64'h0, 1'b1));
    add_row(blk_row(fbc_pkg::OP_DEC, '1, 1'b0));
    // Single round, asymmetric key, zero IV
    add_row(cfg_row(fbc_pkg::CFG_BASE_KEY, 64'h8001));
    add_row(cfg_row(fbc_pkg::CFG_ROUND_COUNT, 64'd1));
    add_row(blk_row(fbc_pkg::OP_ENC, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0));
    add_row(blk_row(fbc_pkg::OP_DEC, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0));
    add_row(cfg_row(fbc_pkg::CFG_INIT_VECTOR, 64'h0));
    add_row(blk_row(fbc_pkg::OP_ENC, 64'h8000_0000_0000_0001, 1'b1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_blocks();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_block(dir_rows[i].op, dir_rows[i].val, dir_rows[i].rs,
                   dir_rows[i].known, dir_rows[i].want);
      end
    end

    // Random phases: new settings each time, idling pattern rotates
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_blocks();
      case (p)
        0:       rounds = 8'd255;
        1:       rounds = fbc_pkg::RST_ROUND_COUNT;
        2:       rounds = 8'd0;
        default: rounds = fbc_pkg::RND_W'($urandom_range(1, 12));
      endcase
      case (p)
        0:       key = 16'hFFFF;
        2:       key = 16'h0000;
        default: key = fbc_pkg::WORD_W'($urandom);
      endcase
      case (p)
        0:       iv = '1;
        1:       iv = '0;
        default: iv = {$urandom, $urandom};
      endcase
      mode    = (p % 3 == 2) ? fbc_pkg::MODE_ECB : fbc_pkg::MODE_CBC;
      n_items = (p < 2) ? 30 : 114;
      write_reg(fbc_pkg::CFG_BASE_KEY, fbc_pkg::CDAT_W'(key));
      write_reg(fbc_pkg::CFG_ROUND_COUNT, fbc_pkg::CDAT_W'(rounds));
      write_reg(fbc_pkg::CFG_CHAIN_MODE, fbc_pkg::CDAT_W'(mode));
      write_reg(fbc_pkg::CFG_INIT_VECTOR, iv);

      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      if (p == PRESSURE_PH) hold_req = 1'b1;

      // Messages: a restart now and then, random content in between
      repeat (n_items)
        send_block(logic'($urandom_range(1)), {$urandom, $urandom},
                   ($urandom_range(7) == 0), 1'b0, '0);
    end

    drain_blocks();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fbc_pkg.sv
rtl/fbc_round.sv
rtl/fbc_ctrl.sv
rtl/feistel_block_cipher_cbc_unit.sv
rtl/fbc_checker.sv
test/feistel_block_cipher_cbc_unit_tb.sv
